// ----- design/lbs_pkg.sv -----
// Shared types, constants and arithmetic helpers for the skinning block.
package lbs_pkg;

  localparam int MaxJoints  = 256;
  localparam int JointW     = $clog2(MaxJoints);
  localparam int NumElems   = 12;
  localparam int Influences = 4;
  localparam int FracBits   = 16;

  localparam logic [8:0]  BlendOne = 9'd256;
  localparam logic [43:0] DivBias  = 44'(255) << 35;
  localparam logic [37:0] QBias    = 38'(1) << 35;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpSkin  = 2'd1,
    OpBlend = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    logic            blend;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] prev;
  } item_t;

  typedef struct packed {
    logic [43:0] x;
    logic [36:0] q;
  } div_t;

  // One digit of a division by 255: 256 = 255 + 1, so x = 256*h + l is 255*h + (h + l).
  function automatic div_t div_step(div_t a);
    div_t r;
    r.q = a.q + 37'(a.x >> 8);
    r.x = {36'b0, a.x[7:0]} + (a.x >> 8);
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/linear_blend_skinning.sv -----
// A skin item holds the matrix reader while it reads its four joints, one joint matrix per
// cycle from twelve element memories while the output is not stalled; the next skin item
// is taken during the last read. Loads are taken every cycle when the reader is free; the
// back end stalls while a result waits on out_ready_i.
// Reset clears control state and sets the blend factor to 256; matrices are undefined
// until loaded.
module linear_blend_skinning (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  joint_slot_i,
  input  logic [3:0]  element_slot_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] prev_x_i,
  input  logic signed [31:0] prev_y_i,
  input  logic signed [31:0] prev_z_i,
  input  logic [31:0] joint_list_i,
  input  logic [31:0] weight_list_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o
);

  localparam int NE = lbs_pkg::NumElems;

  logic [8:0] blend_q;
  logic       adv;
  logic       in_acc, skin_acc, load_acc, rd_fire;
  lbs_pkg::op_e op;

  logic       busy_q, busy_d;
  logic [1:0] cnt_q;
  lbs_pkg::item_t it_q;
  logic [31:0] joints_q, weights_q;

  logic [7:0] rd_jnt, rd_wt;
  logic [NE-1:0][31:0] rd_w;

  logic a_v_q, a_first_q, a_last_q, a_use_q;
  logic [7:0] a_w_q;
  lbs_pkg::item_t a_item_q;

  logic [NE-1:0][41:0] acc_q, acc_d;
  logic b_v_q;
  lbs_pkg::item_t b_item_q;

  lbs_pkg::div_t [NE-1:0] c1_q, c2_q, c3_q, c1_d, c2_d, c3_d;
  logic c1_v_q, c2_v_q, c3_v_q;
  lbs_pkg::item_t c1_item_q, c2_item_q, c3_item_q;

  logic [NE-1:0][31:0] d_b_q, d_b_d;
  logic d_v_q;
  lbs_pkg::item_t d_item_q;

  logic [8:0][63:0] e_p_q, e_p_d;
  logic [2:0][31:0] e_t_q;
  logic e_v_q;
  lbs_pkg::item_t e_item_q;

  logic [2:0][31:0] f_sk_q, f_sk_d;
  logic f_v_q;
  lbs_pkg::item_t f_item_q;

  logic [2:0][42:0] g_m_q, g_m_d;
  logic [2:0][31:0] g_sk_q;
  logic g_v_q;
  lbs_pkg::item_t g_item_q;

  logic [2:0][31:0] res_d, res_q;
  logic out_v_q;

  logic [8:0] fac;

  assign op       = lbs_pkg::op_e'(op_i);
  assign adv      = !out_v_q || out_ready_i;
  assign in_ready_o = !busy_q || (adv && (cnt_q == 2'd3));
  assign in_acc   = in_valid_i && in_ready_o;
  assign skin_acc = in_acc && ((op == lbs_pkg::OpSkin) || (op == lbs_pkg::OpBlend));
  assign load_acc = in_acc && (op == lbs_pkg::OpLoad) &&
                    (32'(joint_slot_i) < 32'(lbs_pkg::MaxJoints)) &&
                    (32'(element_slot_i) < 32'(NE));
  assign rd_fire  = busy_q && adv;

  assign rd_jnt = joints_q[{cnt_q, 3'b000} +: 8];
  assign rd_wt  = weights_q[{cnt_q, 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= lbs_pkg::BlendOne;
    end else if (cfg_we_i) begin
      blend_q <= cfg_wdata_i;
    end
  end

  for (genvar e = 0; e < NE; e++) begin : g_mem
    logic [31:0] mem_q [lbs_pkg::MaxJoints];
    logic [31:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (load_acc && (32'(element_slot_i) == e)) begin
        mem_q[joint_slot_i[lbs_pkg::JointW-1:0]] <= element_value_i;
      end
      if (rd_fire) begin
        rd_q <= mem_q[rd_jnt[lbs_pkg::JointW-1:0]];
      end
    end
    assign rd_w[e] = rd_q;
  end

  always_comb begin
    busy_d = busy_q;
    if (rd_fire && (cnt_q == 2'd3)) begin
      busy_d = skin_acc;
    end else if (skin_acc) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c1_v_q  <= 1'b0;
      c2_v_q  <= 1'b0;
      c3_v_q  <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (rd_fire) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (skin_acc) begin
        cnt_q <= '0;
      end
      if (adv) begin
        a_v_q   <= busy_q;
        b_v_q   <= a_v_q && a_last_q;
        c1_v_q  <= b_v_q;
        c2_v_q  <= c1_v_q;
        c3_v_q  <= c2_v_q;
        d_v_q   <= c3_v_q;
        e_v_q   <= d_v_q;
        f_v_q   <= e_v_q;
        g_v_q   <= f_v_q;
        out_v_q <= g_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skin_acc) begin
      it_q.blend <= (op == lbs_pkg::OpBlend);
      it_q.pos   <= {pos_z_i, pos_y_i, pos_x_i};
      it_q.prev  <= {prev_z_i, prev_y_i, prev_x_i};
      joints_q   <= joint_list_i;
      weights_q  <= weight_list_i;
    end
  end

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      acc_d[e] = (a_first_q ? 42'd0 : acc_q[e]) +
                 (a_use_q ? 42'($signed({1'b0, a_w_q}) * $signed(rd_w[e])) : 42'd0);
      c1_d[e] = lbs_pkg::div_step(lbs_pkg::div_step(
                  '{x: 44'($signed(acc_q[e])) + 44'd127 + lbs_pkg::DivBias, q: '0}));
      c2_d[e] = lbs_pkg::div_step(lbs_pkg::div_step(c1_q[e]));
      c3_d[e] = lbs_pkg::div_step(lbs_pkg::div_step(c2_q[e]));
      d_b_d[e] = lbs_pkg::sat32(66'($signed({1'b0, c3_q[e].q} +
                  38'(c3_q[e].x >= 44'd255)) - $signed(lbs_pkg::QBias)));
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e_p_d[r*3+c] = 64'($signed(d_b_q[r*4+c]) * $signed(d_item_q.pos[c]));
      end
      f_sk_d[r] = lbs_pkg::sat32(((66'($signed(e_p_q[r*3])) + 66'($signed(e_p_q[r*3+1])) +
                   66'($signed(e_p_q[r*3+2])) + (66'sd1 <<< (lbs_pkg::FracBits - 1)))
                   >>> lbs_pkg::FracBits) + 66'($signed(e_t_q[r])));
      g_m_d[r] = 43'(($signed({f_sk_q[r][31], f_sk_q[r]}) -
                  $signed({f_item_q.prev[r][31], f_item_q.prev[r]})) * $signed({1'b0, fac}));
      res_d[r] = g_item_q.blend ?
                 g_item_q.prev[r] + 32'(($signed(g_m_q[r]) + 43'sd128) >>> 8) : g_sk_q[r];
    end
  end

  assign fac = (blend_q > lbs_pkg::BlendOne) ? lbs_pkg::BlendOne : blend_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_first_q <= (cnt_q == 2'd0);
      a_last_q  <= (cnt_q == 2'd3);
      a_use_q   <= (rd_wt != 8'd0) && (32'(rd_jnt) < 32'(lbs_pkg::MaxJoints));
      a_w_q     <= rd_wt;
      a_item_q  <= it_q;
      if (a_v_q) begin
        acc_q <= acc_d;
      end
      b_item_q  <= a_item_q;
      c1_q      <= c1_d;
      c1_item_q <= b_item_q;
      c2_q      <= c2_d;
      c2_item_q <= c1_item_q;
      c3_q      <= c3_d;
      c3_item_q <= c2_item_q;
      d_b_q     <= d_b_d;
      d_item_q  <= c3_item_q;
      e_p_q     <= e_p_d;
      e_t_q     <= {d_b_q[11], d_b_q[7], d_b_q[3]};
      e_item_q  <= d_item_q;
      f_sk_q    <= f_sk_d;
      f_item_q  <= e_item_q;
      g_m_q     <= g_m_d;
      g_sk_q    <= f_sk_q;
      g_item_q  <= f_item_q;
      res_q     <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];

  a_ready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q != 2'd3) |-> !in_ready_o) else $error("ready before last read");
  a_first_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q |-> !(a_first_q && a_last_q)) else $error("first and last read coincide");
  a_sum_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && a_v_q && a_last_q |=> b_v_q) else $error("accumulated sum lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(g_v_q) && $stable(out_v_q)) else $error("pipeline moved during stall");

endmodule

// ----- tb/lbs_checker.sv -----
// Checker that predicts skinned vertex positions and compares them with the block's results.
`timescale 1ns / 1ps
module lbs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  joint_slot_i,
  input  logic [3:0]  element_slot_i,
  input  logic [31:0] element_value_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] prev_x_i,
  input  logic [31:0] prev_y_i,
  input  logic [31:0] prev_z_i,
  input  logic [31:0] joint_list_i,
  input  logic [31:0] weight_list_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_x_i,
  input  logic [31:0] out_y_i,
  input  logic [31:0] out_z_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  typedef logic [2:0][31:0] vec_t;

  logic [31:0] matrix_store [lbs_pkg::MaxJoints*lbs_pkg::NumElems];
  logic [8:0]  blend_reg;
  vec_t        expected_pos [$];

  function automatic longint sat_val(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic vec_t skin_vertex(vec_t pos, logic [31:0] joints, logic [31:0] weights);
    longint sum [lbs_pkg::NumElems];
    longint bm [lbs_pkg::NumElems];
    longint hi, lo, p;
    vec_t   res;
    int     jnt, w;
    for (int e = 0; e < lbs_pkg::NumElems; e++) sum[e] = 0;
    for (int i = 0; i < 4; i++) begin
      jnt = joints[8*i +: 8];
      w = weights[8*i +: 8];
      if (w != 0 && jnt < lbs_pkg::MaxJoints) begin
        for (int e = 0; e < lbs_pkg::NumElems; e++)
          sum[e] += longint'(w) *
                    longint'($signed(matrix_store[jnt*lbs_pkg::NumElems+e]));
      end
    end
    for (int e = 0; e < lbs_pkg::NumElems; e++)
      bm[e] = sat_val(div_floor(2 * sum[e] + 255, 510));
    for (int r = 0; r < 3; r++) begin
      hi = 0;
      lo = 0;
      for (int c = 0; c < 3; c++) begin
        p = bm[r*4+c] * longint'($signed(pos[c]));
        hi += p >>> lbs_pkg::FracBits;
        lo += p & ((64'sd1 << lbs_pkg::FracBits) - 1);
      end
      lo += 64'sd1 << (lbs_pkg::FracBits - 1);
      res[r] = 32'(sat_val(hi + (lo >>> lbs_pkg::FracBits) + bm[r*4+3]));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vec_t pos, prv, sk, got, want;
    int   f;
    if (!rst_ni) begin
      blend_reg <= lbs_pkg::BlendOne;
      fail_count_o = 0;
      results_o = 0;
      expected_pos.delete();
    end else begin
      if (cfg_we_i) blend_reg <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        pos = {pos_z_i, pos_y_i, pos_x_i};
        prv = {prev_z_i, prev_y_i, prev_x_i};
        unique case (lbs_pkg::op_e'(op_i))
          lbs_pkg::OpLoad: begin
            if (element_slot_i < lbs_pkg::NumElems)
              matrix_store[joint_slot_i*lbs_pkg::NumElems+element_slot_i] = element_value_i;
          end
          lbs_pkg::OpSkin: begin
            expected_pos.insert(expected_pos.size(),
                                skin_vertex(pos, joint_list_i, weight_list_i));
          end
          lbs_pkg::OpBlend: begin
            f = (blend_reg > lbs_pkg::BlendOne) ? 256 : blend_reg;
            if (f != 0) begin
              sk = skin_vertex(pos, joint_list_i, weight_list_i);
              for (int k = 0; k < 3; k++)
                prv[k] = 32'(longint'($signed(prv[k])) + (((longint'($signed(sk[k]))
                         - longint'($signed(prv[k]))) * f + 128) >>> 8));
            end
            expected_pos.insert(expected_pos.size(), prv);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_z_i, out_y_i, out_x_i};
        results_o++;
        if (expected_pos.size() == 0) begin
          report_mismatch("unexpected result x", got[0], '0);
        end else begin
          want = expected_pos.pop_front();
          if (got[0] !== want[0]) report_mismatch("out_x", got[0], want[0]);
          if (got[1] !== want[1]) report_mismatch("out_y", got[1], want[1]);
          if (got[2] !== want[2]) report_mismatch("out_z", got[2], want[2]);
        end
      end
    end
    pending_o = expected_pos.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the skinning testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = lbs_pkg::OpLoad;
  logic [7:0]  joint_slot_i = '0;
  logic [3:0]  element_slot_i = '0;
  logic [31:0] element_value_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] prev_x_i = '0, prev_y_i = '0, prev_z_i = '0;
  logic [31:0] joint_list_i = '0, weight_list_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  int          fail_count, pending, results;
  bit          calm = 1'b0;
  int          skins = 0;

  always #5 clk_i = ~clk_i;

  linear_blend_skinning u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .op_i,
    .joint_slot_i, .element_slot_i, .element_value_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .prev_x_i, .prev_y_i, .prev_z_i, .joint_list_i, .weight_list_i,
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .out_z_o
  );

  lbs_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o), .op_i,
    .joint_slot_i, .element_slot_i, .element_value_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .prev_x_i, .prev_y_i, .prev_z_i, .joint_list_i, .weight_list_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_x_i(out_x_o), .out_y_i(out_y_o),
    .out_z_i(out_z_o), .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 14);
  end

  function automatic logic [31:0] rand_q();
    unique case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      default: return $urandom;
    endcase
  endfunction

  // Random skin items only name joints 0..7, which are fully loaded first.
  function automatic logic [31:0] rand_joints();
    logic [31:0] j;
    for (int i = 0; i < 4; i++)
      j[8*i +: 8] = $urandom_range(7);
    return j;
  endfunction

  task automatic send(logic [1:0] op, logic [7:0] js, logic [3:0] es, logic [31:0] ev,
                      logic [31:0] jl, logic [31:0] wl);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    joint_slot_i <= js;
    element_slot_i <= es;
    element_value_i <= ev;
    pos_x_i <= rand_q();
    pos_y_i <= rand_q();
    pos_z_i <= rand_q();
    prev_x_i <= rand_q();
    prev_y_i <= rand_q();
    prev_z_i <= rand_q();
    joint_list_i <= jl;
    weight_list_i <= wl;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == lbs_pkg::OpSkin || op == lbs_pkg::OpBlend) skins++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_blend(logic [8:0] f);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_joint(int j, bit identity);
    for (int e = 0; e < lbs_pkg::NumElems; e++)
      send(lbs_pkg::OpLoad, 8'(j), 4'(e),
           identity ? ((e % 5 == 0) ? 32'h00010000 : 32'h0) : rand_q(), '0, '0);
  endtask

  initial begin
    logic [31:0] wl;
    logic [1:0]  op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_joint(0, 1'b1);
    for (int j = 1; j < 8; j++) load_joint(j, 1'b0);
    load_joint(255, 1'b0);
    send(lbs_pkg::OpLoad, 8'd3, 4'd12, 32'hDEAD, '0, '0);
    send(lbs_pkg::OpLoad, 8'd3, 4'd15, 32'hBEEF, '0, '0);
    send(lbs_pkg::OpSkin, '0, '0, '0, 32'h0, 32'h000000FF);
    send(lbs_pkg::OpSkin, '0, '0, '0, 32'hFF030201, 32'hFFFFFFFF);
    send(lbs_pkg::OpSkin, '0, '0, '0, 32'h07060504, 32'h0);
    send(lbs_pkg::OpSkin, '0, '0, '0, 32'h00000000, 32'h80402010);
    send(lbs_pkg::OpNone, '0, '0, '0, 32'h01, 32'hFF);
    send(lbs_pkg::OpBlend, '0, '0, '0, 32'h03020100, 32'h40404040);
    set_blend(9'd0);
    send(lbs_pkg::OpBlend, '0, '0, '0, 32'h03020100, 32'h40404040);
    set_blend(9'h1FF);
    send(lbs_pkg::OpBlend, '0, '0, '0, 32'h03020100, 32'h40404040);
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: set_blend(9'd128);
        1: set_blend(9'd1);
        2: set_blend(9'($urandom_range(511)));
        default: set_blend(9'd256);
      endcase
      calm = (phase == 2);
      for (int n = 0; n < 340; n++) begin
        op = ($urandom_range(99) < 60) ? lbs_pkg::OpSkin :
             ($urandom_range(99) < 60 ? lbs_pkg::OpBlend :
             ($urandom_range(9) == 0 ? lbs_pkg::OpNone : lbs_pkg::OpLoad));
        wl = ($urandom_range(3) == 0) ? $urandom : {8'($urandom_range(63)),
             8'($urandom_range(63)), 8'($urandom_range(63)), 8'($urandom_range(127))};
        if (op == lbs_pkg::OpLoad)
          send(lbs_pkg::OpLoad,
               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
               4'($urandom), rand_q(), '0, '0);
        else
          send(op, 8'($urandom), 4'($urandom), $urandom, rand_joints(), wl);
        if (n == 170) drain();
      end
      calm = 1'b0;
    end
    drain();
    $display("Covered %0d skin items and %0d checked results over several blend settings.",
             skins, results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
